/* sv/gb5_pkg.sv */
`timescale 1ns / 1ps

package gb5_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int MIN_DIM      = 5;

	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	// row counter runs two lines past the frame while draining
	localparam int ROW_W        = 14;
	localparam int CH_W         = 8;
	localparam int CSUM_W       = 12;
	localparam int HSUM_W       = 16;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		ACT_PIXEL = 1'b0,
		ACT_DRAIN = 1'b1
	} action_t;

	typedef struct packed {
		logic [CH_W-1:0] alpha;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pix_t;

	typedef logic [CSUM_W-1:0] csum_t;

	typedef struct packed {
		csum_t blue;
		csum_t green;
		csum_t red;
	} csum3_t;

	// 1 4 6 4 1 weighted sum of one channel down a window column
	function automatic csum_t col_sum(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
		input logic [CH_W-1:0] c, input logic [CH_W-1:0] d, input logic [CH_W-1:0] e);
		csum_t s;
		s = CSUM_W'(a) + (CSUM_W'(b) << 2) + (CSUM_W'(c) << 2) + (CSUM_W'(c) << 1)
			+ (CSUM_W'(d) << 2) + CSUM_W'(e);
		return s;
	endfunction

	// 1 4 6 4 1 weighted sum across the column sums, rounded half up over 256
	function automatic logic [CH_W-1:0] row_round(input csum_t a, input csum_t b, input csum_t c,
		input csum_t d, input csum_t e);
		logic [HSUM_W:0] s;
		s = (HSUM_W+1)'(a) + ((HSUM_W+1)'(b) << 2) + ((HSUM_W+1)'(c) << 2)
			+ ((HSUM_W+1)'(c) << 1) + ((HSUM_W+1)'(d) << 2) + (HSUM_W+1)'(e)
			+ (HSUM_W+1)'(128);
		return s[HSUM_W-1:HSUM_W-CH_W];
	endfunction

endpackage

/* sv/gb5_linebuf.sv */
`timescale 1ns / 1ps

module gb5_linebuf #(
	parameter int Depth = gb5_pkg::MAX_WIDTH,
	parameter int DataW = 4 * $bits(gb5_pkg::pix_t)
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [DataW-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [DataW-1:0]         wr_data
);

	logic [DataW-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// write-first: a read of the column being written sees the new data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

endmodule

/* sv/gaussian_blur_5x5_rgba.sv */
`timescale 1ns / 1ps

// 5x5 binomial blur on an RGBA raster stream.
// Pixels enter on s_axis (tuser = 0, RGBA in tdata) in raster order, one per
// clock. Red, green and blue are filtered with [1 4 6 4 1]^2 / 256, rounded
// half up; alpha passes through. Pixels within two of a frame edge keep their
// original color. A result belongs to the pixel two lines and two pixels
// behind the input, so after the last pixel of a frame send 2*width+2 drain
// requests (tuser = 1) to flush the tail; m_axis tlast marks the frame's
// last pixel. Drain requests outside that window are taken and dropped.
// Throughput is one request per cycle while m_axis does not stall; a result
// passes the line read stage, window stage and output register. The line
// memory is read at one column and written at one column each cycle.
// cfg writes width (index 0) or height (index 1) and restart the frame;
// write only while the block is idle.
// Reset sets 640 x 480 and an empty pipeline; line memory contents are kept
// undefined, they never reach a result. When m_axis stalls the pipeline
// holds and s_axis_tready drops once all three stages are full.
module gaussian_blur_5x5_rgba #(
	parameter int MaxWidth = gb5_pkg::MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,  // red, green, blue, alpha
	input  logic [0:0]                    s_axis_tuser,  // action
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [31:0]                   m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
	output logic                          m_axis_tlast,  // frame_end
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [0:0]                    cfg_index,
	input  logic [gb5_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ColW  = $clog2(MaxWidth);
	localparam int DimW  = $clog2(MaxWidth + 1);
	localparam int ExtW  = (DimW > gb5_pkg::WIDTH_REG_W) ? DimW : gb5_pkg::WIDTH_REG_W;
	localparam int RowW  = gb5_pkg::ROW_W;
	localparam int HW    = gb5_pkg::HEIGHT_REG_W;
	localparam int PixW  = $bits(gb5_pkg::pix_t);
	localparam int WResetInt = (gb5_pkg::WIDTH_RESET > MaxWidth) ? MaxWidth
		: gb5_pkg::WIDTH_RESET;
	localparam logic [DimW-1:0] WReset = DimW'(WResetInt);
	localparam logic [HW-1:0]   HReset = HW'(gb5_pkg::HEIGHT_RESET);

	// effective frame size, saturated when written
	logic [DimW-1:0] eff_w_q;
	logic [HW-1:0]   eff_h_q;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;

	logic [ExtW-1:0] w_wr;
	logic [HW-1:0]   h_wr;
	logic            cfg_acc;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_comb begin
		w_wr = ExtW'(cfg_data[gb5_pkg::WIDTH_REG_W-1:0]);
		if (w_wr < ExtW'(gb5_pkg::MIN_DIM)) begin
			w_wr = ExtW'(gb5_pkg::MIN_DIM);
		end else if (w_wr > ExtW'(MaxWidth)) begin
			w_wr = ExtW'(MaxWidth);
		end
		h_wr = cfg_data[HW-1:0];
		if (h_wr < HW'(gb5_pkg::MIN_DIM)) begin
			h_wr = HW'(gb5_pkg::MIN_DIM);
		end
	end

	// ---------------- input decode ----------------
	logic            in_acc;
	logic            is_drain;
	logic            frame_done;
	logic            live;
	logic [ColW-1:0] cur_col;
	logic [RowW-1:0] cur_row;
	logic [RowW-1:0] h_ext;
	logic [DimW-1:0] cur_col_w;
	logic            col_wrap;
	logic            emit;
	logic [RowW-1:0] pr;
	logic [DimW-1:0] pc;
	logic            border;
	logic            last_pix;
	logic            adv1;
	logic            adv2;
	logic            valid_s1;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign is_drain = (gb5_pkg::action_t'(s_axis_tuser) == gb5_pkg::ACT_DRAIN);
	assign h_ext    = RowW'(eff_h_q);
	assign frame_done = (row_q >= h_ext);

	always_comb begin
		// a pixel after the frame's end starts a new frame
		if (!is_drain && frame_done) begin
			cur_col = '0;
			cur_row = '0;
		end else begin
			cur_col = col_q;
			cur_row = row_q;
		end
		if (is_drain) begin
			live = frame_done && ((row_q == h_ext) || (row_q == h_ext + RowW'(1))
				|| ((row_q == h_ext + RowW'(2)) && (col_q < ColW'(2))));
		end else begin
			live = 1'b1;
		end
	end

	assign cur_col_w = DimW'(cur_col);
	assign col_wrap  = (cur_col_w + DimW'(1) == eff_w_q);
	assign emit      = (cur_row >= RowW'(3)) || ((cur_row == RowW'(2)) && (cur_col >= ColW'(2)));

	always_comb begin
		if (cur_col >= ColW'(2)) begin
			pr = cur_row - RowW'(2);
			pc = cur_col_w - DimW'(2);
		end else begin
			pr = cur_row - RowW'(3);
			pc = cur_col_w + eff_w_q - DimW'(2);
		end
		border = (pr < RowW'(2)) || (pr >= h_ext - RowW'(2))
			|| (pc < DimW'(2)) || (pc >= eff_w_q - DimW'(2));
		last_pix = (pr == h_ext - RowW'(1)) && (pc == eff_w_q - DimW'(1));
	end

	assign s_axis_tready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WReset;
			eff_h_q <= HReset;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_acc) begin
			unique case (gb5_pkg::cfg_reg_t'(cfg_index))
				gb5_pkg::REG_WIDTH:  eff_w_q <= DimW'(w_wr);
				gb5_pkg::REG_HEIGHT: eff_h_q <= h_wr;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc && live) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= cur_row + RowW'(1);
			end else begin
				col_q <= cur_col + ColW'(1);
				row_q <= cur_row;
			end
		end
	end

	// ---------------- stage 1: line memory read ----------------
	gb5_pkg::pix_t   pix_s1;
	logic [ColW-1:0] col_s1;
	logic            emit_s1;
	logic            border_s1;
	logic            last_s1;
	logic [4*PixW-1:0] lines_rd;
	logic [4*PixW-1:0] lines_wr;
	gb5_pkg::pix_t   c0, c1, c2, c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc && live) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && live) begin
			pix_s1    <= is_drain ? '0 : gb5_pkg::pix_t'(s_axis_tdata);
			col_s1    <= cur_col;
			emit_s1   <= emit;
			border_s1 <= border;
			last_s1   <= last_pix;
		end
	end

	assign c0 = lines_rd[0*PixW +: PixW];
	assign c1 = lines_rd[1*PixW +: PixW];
	assign c2 = lines_rd[2*PixW +: PixW];
	assign c3 = lines_rd[3*PixW +: PixW];
	// shift each column up one line, the new pixel into the newest line
	assign lines_wr = {pix_s1, c3, c2, c1};

	gb5_linebuf #(
		.Depth(MaxWidth),
		.DataW(4 * PixW)
	) u_linebuf (
		.clk    (clk),
		.rd_en  (in_acc && live),
		.rd_addr(cur_col),
		.rd_data(lines_rd),
		.wr_en  (adv1),
		.wr_addr(col_s1),
		.wr_data(lines_wr)
	);

	// ---------------- window: column sums and centre row ----------------
	gb5_pkg::csum3_t vs_q  [5];
	gb5_pkg::pix_t   ctr_q [5];
	gb5_pkg::csum3_t vs_new;
	logic            valid_s2;
	logic            border_s2;
	logic            last_s2;
	logic            out_valid_q;

	assign vs_new.red   = gb5_pkg::col_sum(c0.red, c1.red, c2.red, c3.red, pix_s1.red);
	assign vs_new.green = gb5_pkg::col_sum(c0.green, c1.green, c2.green, c3.green, pix_s1.green);
	assign vs_new.blue  = gb5_pkg::col_sum(c0.blue, c1.blue, c2.blue, c3.blue, pix_s1.blue);

	assign adv1 = valid_s1 && (!valid_s2 || adv2);
	assign adv2 = valid_s2 && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int j = 0; j < 4; j++) begin
				vs_q[j]  <= vs_q[j+1];
				ctr_q[j] <= ctr_q[j+1];
			end
			vs_q[4]  <= vs_new;
			ctr_q[4] <= c2;
		end
	end

	// ---------------- stage 2: window holds the result's neighborhood ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			valid_s2 <= emit_s1;
		end else if (adv2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			border_s2 <= border_s1;
			last_s2   <= last_s1;
		end
	end

	// ---------------- output register ----------------
	gb5_pkg::pix_t blur;
	gb5_pkg::pix_t out_q;
	logic          out_last_q;

	always_comb begin
		blur.red   = gb5_pkg::row_round(vs_q[0].red, vs_q[1].red, vs_q[2].red,
			vs_q[3].red, vs_q[4].red);
		blur.green = gb5_pkg::row_round(vs_q[0].green, vs_q[1].green, vs_q[2].green,
			vs_q[3].green, vs_q[4].green);
		blur.blue  = gb5_pkg::row_round(vs_q[0].blue, vs_q[1].blue, vs_q[2].blue,
			vs_q[3].blue, vs_q[4].blue);
		blur.alpha = ctr_q[2].alpha;
		if (border_s2) begin
			blur.red   = ctr_q[2].red;
			blur.green = ctr_q[2].green;
			blur.blue  = ctr_q[2].blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv2) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			out_q      <= blur;
			out_last_q <= last_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tlast  = out_last_q;

endmodule

/* sv/gb5_checker.sv */
`timescale 1ns / 1ps

module gb5_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// input backpressure only comes from a stalled output
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

	// pipeline is empty right after reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !m_axis_tvalid && s_axis_tready)
		else $error("pipeline not empty after reset");

endmodule

bind gaussian_blur_5x5_rgba gb5_checker u_gb5_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);
